>>> src/slfs_pkg.sv
// Shared types, constants and the character-to-segment table of the segment
// LCD frame serializer. No dependencies.
`default_nettype none

package slfs_pkg;

    // Number of segment bytes in one frame and characters in one row
    localparam int unsigned NUM_SEG   = 8;
    localparam int unsigned ROW_CHARS = 4;

    // Word index inside a frame transaction: header is 0, bytes are 1..8
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] IDX_HEADER = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LAST   = 4'd8;

    // Output word formats
    localparam logic [11:0] HEADER_WORD = 12'h150;   // 101, address 0x10
    localparam logic [2:0]  CMD_PREFIX  = 3'b100;
    localparam logic [3:0]  CNT_HEADER  = 4'd9;
    localparam logic [3:0]  CNT_BYTE    = 4'd8;
    localparam logic [3:0]  CNT_CMD     = 4'd12;

    // Operation codes carried on the input tuser
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Flag bit positions
    localparam logic [7:0] DOT_UPPER_BIT = 8'h80;   // byte 2
    localparam logic [7:0] DOT_LOWER_BIT = 8'h08;   // byte 5
    localparam logic [7:0] SYM_HIGH_BIT  = 8'h80;   // bytes 1 and 3
    localparam logic [7:0] SYM_LOW_BIT   = 8'h08;   // bytes 4, 6 and 7

    // One decoded frame (or command) handed to the serializer
    typedef struct packed {
        logic                         op;
        logic [NUM_SEG-1:0][7:0]      seg;
        logic [7:0]                   cmd;
    } frame_t;

    // Segment code of one character: upper row code in [15:8], lower in [7:0].
    // Unknown characters give zero.
    function automatic logic [15:0] glyph(input logic [7:0] ch);
        logic [15:0] code;
        case (ch)
            8'h30:   code = 16'h5FF5;   // '0'
            8'h31:   code = 16'h5005;   // '1'
            8'h32:   code = 16'h3DB6;   // '2'
            8'h33:   code = 16'h7997;   // '3'
            8'h34:   code = 16'h7247;   // '4'
            8'h35:   code = 16'h6BD3;   // '5'
            8'h36:   code = 16'h6FF3;   // '6'
            8'h37:   code = 16'h5185;   // '7'
            8'h38:   code = 16'h7FF7;   // '8'
            8'h39:   code = 16'h7BD7;   // '9'
            8'h43:   code = 16'h0F05;   // 'C'
            8'h49:   code = 16'h5005;   // 'I'
            8'h55:   code = 16'h5E75;   // 'U'
            8'h41:   code = 16'h7798;   // 'A'
            8'h48:   code = 16'h764B;   // 'H'
            8'h53:   code = 16'h6BD3;   // 'S'
            8'h4C:   code = 16'h0E70;   // 'L'
            8'h50:   code = 16'h37D9;   // 'P'
            8'h45:   code = 16'h2FF2;   // 'E'
            8'h47:   code = 16'h6FF3;   // 'G'
            8'h2D:   code = 16'h2002;   // '-'
            default: code = 16'h0000;   // space and anything unknown
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> src/slfs_lane.sv
// One character decode lane: looks up a character in the segment table for
// its row. Depends on slfs_pkg.
`default_nettype none

module slfs_lane (
    input  wire logic [7:0] ch,
    input  wire logic       lower_row,
    output logic [7:0]      code
);

    logic [15:0] both;

    assign both = slfs_pkg::glyph(ch);
    assign code = lower_row ? both[7:0] : both[15:8];

endmodule

`default_nettype wire

>>> src/slfs_merge.sv
// Merging stage: gathers the eight lane codes into a frame and ORs in the
// dot and symbol flags. Depends on slfs_pkg.
`default_nettype none

module slfs_merge (
    input  wire logic                                    op,
    input  wire logic [slfs_pkg::NUM_SEG-1:0][7:0]       lane_code,
    input  wire logic [1:0]                              decimal_points,
    input  wire logic [4:0]                              symbol_flags,
    input  wire logic [7:0]                              command_byte,
    output slfs_pkg::frame_t                             frame
);

    always_comb begin
        frame.op  = op;
        frame.cmd = command_byte;
        frame.seg = lane_code;
        if (decimal_points[0]) frame.seg[2] = frame.seg[2] | slfs_pkg::DOT_UPPER_BIT;
        if (decimal_points[1]) frame.seg[5] = frame.seg[5] | slfs_pkg::DOT_LOWER_BIT;
        if (symbol_flags[0])   frame.seg[1] = frame.seg[1] | slfs_pkg::SYM_HIGH_BIT;
        if (symbol_flags[1])   frame.seg[3] = frame.seg[3] | slfs_pkg::SYM_HIGH_BIT;
        if (symbol_flags[2])   frame.seg[4] = frame.seg[4] | slfs_pkg::SYM_LOW_BIT;
        if (symbol_flags[3])   frame.seg[6] = frame.seg[6] | slfs_pkg::SYM_LOW_BIT;
        if (symbol_flags[4])   frame.seg[7] = frame.seg[7] | slfs_pkg::SYM_LOW_BIT;
    end

endmodule

`default_nettype wire

>>> src/slfs_serializer.sv
// Word sequencer: holds one decoded frame and issues its header and segment
// bytes, or a single command word, into a registered output. Depends on slfs_pkg.
`default_nettype none

module slfs_serializer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load_valid,
    output logic                   load_ready,
    input  wire slfs_pkg::frame_t  load_frame,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [11:0]            m_word,
    output logic [3:0]             m_count,
    output logic                   m_msb_first,
    output logic                   m_last
);

    logic                         busy_reg, busy_next;
    logic [slfs_pkg::IDX_W-1:0]   idx_reg, idx_next;
    slfs_pkg::frame_t             frame_reg, frame_next;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_word_reg, out_word_next;
    logic [3:0]  out_count_reg, out_count_next;
    logic        out_msb_reg, out_msb_next;
    logic        out_last_reg, out_last_next;

    logic        out_free, emit, final_word;
    logic [2:0]  byte_sel;
    logic [7:0]  byte_val;
    logic [11:0] word;
    logic [3:0]  count;
    logic        msb;

    assign out_free   = !out_valid_reg || m_ready;
    assign final_word = (frame_reg.op == slfs_pkg::OP_COMMAND) || (idx_reg == slfs_pkg::IDX_LAST);
    assign emit       = busy_reg && out_free;
    assign load_ready = !busy_reg || (emit && final_word);

    // Word k of a frame carries byte k-1; wraps to byte 7 at index 8
    assign byte_sel = idx_reg[2:0] - 3'd1;
    assign byte_val = frame_reg.seg[byte_sel];

    always_comb begin
        if (frame_reg.op == slfs_pkg::OP_COMMAND) begin
            word  = {slfs_pkg::CMD_PREFIX, frame_reg.cmd, 1'b0};
            count = slfs_pkg::CNT_CMD;
            msb   = 1'b1;
        end else if (idx_reg == slfs_pkg::IDX_HEADER) begin
            word  = slfs_pkg::HEADER_WORD;
            count = slfs_pkg::CNT_HEADER;
            msb   = 1'b1;
        end else begin
            word  = {4'd0, byte_val};
            count = slfs_pkg::CNT_BYTE;
            msb   = 1'b0;
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_msb_next   = out_msb_reg;
        out_last_next  = out_last_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_word_next  = word;
            out_count_next = count;
            out_msb_next   = msb;
            out_last_next  = final_word;
            idx_next       = idx_reg + 4'd1;
            if (final_word) busy_next = 1'b0;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (load_valid && load_ready) begin
            busy_next  = 1'b1;
            idx_next   = slfs_pkg::IDX_HEADER;
            frame_next = load_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= slfs_pkg::IDX_HEADER;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg     <= frame_next;
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_msb_reg   <= out_msb_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_word      = out_word_reg;
    assign m_count     = out_count_reg;
    assign m_msb_first = out_msb_reg;
    assign m_last      = out_last_reg;

endmodule

`default_nettype wire

>>> src/segment_lcd_frame_serializer.sv
// Top level of the segment LCD frame serializer: input register, eight
// character decode lanes, merging stage and word sequencer.
// Depends on slfs_pkg, slfs_lane, slfs_merge and slfs_serializer.
//
// Usage:
//  - Input stream (s_axis_*): one transaction is either a display frame
//    (tuser = 0) or a raw controller command (tuser = 1).
//  - Output stream (m_axis_*): the words to shift out on the LCD data line.
//    A frame gives nine transactions: the 9-bit write header (MSB first),
//    then segment bytes 0..7 (LSB first, tlast on byte 7). A command gives
//    one 12-bit word, MSB first, with tlast set.
//  - Path: the first word of an item passes through the input register,
//    then the decode lanes and merge into the sequencer's frame register,
//    then the output register.
//  - Throughput: the sequencer issues one word per cycle while the receiver
//    does not stall, which sets the rate; a frame occupies it for its nine
//    words and a command for one. The next item is decoded and waiting
//    while the current one drains, so frames follow each other with no gap.
//  - Reset (aresetn low, synchronous) empties the input register, the
//    sequencer and the output register; payload registers keep junk.
//  - Receiver stall: the output word holds while m_axis_tready is low; the
//    sequencer, then the input register, then s_axis_tready back up in turn.
`default_nettype none

module segment_lcd_frame_serializer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] row_one_chars, [63:32] row_two_chars, [65:64] decimal_points,
    // [70:66] symbol_flags, [78:71] command_byte, [79] zero
    input  wire logic [79:0] s_axis_tdata,
    // [0] operation
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [11:0] serial_word, [15:12] bit_count
    output logic [15:0]      m_axis_tdata,
    // [0] msb_first
    output logic             m_axis_tuser,
    // last word of the transaction group; release chip select after it
    output logic             m_axis_tlast
);

    // Input register: hold one item until the sequencer takes it
    logic        in_valid_reg, in_valid_next;
    logic        in_op_reg, in_op_next;
    logic [78:0] in_data_reg, in_data_next;

    logic        load_ready;
    logic        s_fire;

    logic [31:0] row_one, row_two;
    logic [1:0]  dots;
    logic [4:0]  syms;
    logic [7:0]  cmd;

    logic [slfs_pkg::NUM_SEG-1:0][7:0] lane_code;
    slfs_pkg::frame_t                  frame;

    logic [11:0] m_word;
    logic [3:0]  m_count;

    assign s_axis_tready = !in_valid_reg || load_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_op_next    = in_op_reg;
        in_data_next  = in_data_reg;
        // Drop the held item once the sequencer takes it
        if (in_valid_reg && load_ready) in_valid_next = 1'b0;
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_op_next    = s_axis_tuser;
            in_data_next  = s_axis_tdata[78:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_op_reg   <= in_op_next;
        in_data_reg <= in_data_next;
    end

    assign row_one = in_data_reg[31:0];
    assign row_two = in_data_reg[63:32];
    assign dots    = in_data_reg[65:64];
    assign syms    = in_data_reg[70:66];
    assign cmd     = in_data_reg[78:71];

    // Eight decode lanes: the upper row fills bytes 0..3 left to right,
    // the lower row fills bytes 7..4, so its leftmost character lands in byte 7
    for (genvar p = 0; p < slfs_pkg::ROW_CHARS; p++) begin : g_lane
        slfs_lane u_upper (
            .ch        (row_one[8*(3-p) +: 8]),
            .lower_row (1'b0),
            .code      (lane_code[p])
        );
        slfs_lane u_lower (
            .ch        (row_two[8*(3-p) +: 8]),
            .lower_row (1'b1),
            .code      (lane_code[7-p])
        );
    end

    slfs_merge u_merge (
        .op             (in_op_reg),
        .lane_code      (lane_code),
        .decimal_points (dots),
        .symbol_flags   (syms),
        .command_byte   (cmd),
        .frame          (frame)
    );

    slfs_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (in_valid_reg),
        .load_ready  (load_ready),
        .load_frame  (frame),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_word      (m_word),
        .m_count     (m_count),
        .m_msb_first (m_axis_tuser),
        .m_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {m_count, m_word};

    // Segment bytes always go LSB first with eight bits
    a_byte_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:12] == slfs_pkg::CNT_BYTE)
        else $error("segment byte with wrong bit count");

    // The write header carries the fixed address and never ends a group
    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[15:12] == slfs_pkg::CNT_HEADER |->
        !m_axis_tlast && m_axis_tdata[11:0] == slfs_pkg::HEADER_WORD)
        else $error("malformed write header");

    // A command word is always a group of its own
    a_cmd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[15:12] == slfs_pkg::CNT_CMD |-> m_axis_tlast)
        else $error("command word without tlast");

    // A new header or command word follows only a finished group
    a_header_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
        m_axis_tdata[15:12] == slfs_pkg::CNT_BYTE)
        else $error("frame interrupted before its last byte");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for segment_lcd_frame_serializer: frames and commands go in on the
// input stream and every shifted word that comes back is checked against a local predictor.
// Depends on slfs_pkg for the operation codes and on the serializer RTL.

module tb;

    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int          HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int          SETTLE_CYCLES  = 12;    // output pipeline latency plus margin
    localparam logic [11:0] WRITE_HEADER   = 12'h150;
    localparam logic [2:0]  CMD_LEAD       = 3'b100;
    localparam logic [3:0]  BITS_HEADER    = 4'd9;
    localparam logic [3:0]  BITS_SEGMENT   = 4'd8;
    localparam logic [3:0]  BITS_COMMAND   = 4'd12;

    // Receiver behaviour between hold-offs
    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_style_e;

    typedef struct packed {
        logic        op;
        logic [31:0] row_one;
        logic [31:0] row_two;
        logic [1:0]  dots;
        logic [4:0]  symbols;
        logic [7:0]  cmd;
    } lcd_item_t;

    typedef struct packed {
        logic [11:0] bits;
        logic [3:0]  count;
        logic        msb_first;
        logic        last;
    } lcd_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Character, upper-row code, lower-row code
    logic [23:0] glyph_rom [22] = '{
        24'h305FF5, 24'h315005, 24'h323DB6, 24'h337997, 24'h347247, 24'h356BD3,
        24'h366FF3, 24'h375185, 24'h387FF7, 24'h397BD7, 24'h430F05, 24'h495005,
        24'h555E75, 24'h417798, 24'h48764B, 24'h536BD3, 24'h4C0E70, 24'h5037D9,
        24'h452FF2, 24'h476FF3, 24'h2D2002, 24'h200000
    };

    lcd_word_t lcd_words_due [$];
    int        bad_words    = 0;
    int        stuck_cycles = 0;

    // Sender burst shaping
    bit        gaps_on    = 1'b1;
    int        burst_left = 0;

    // Receiver control: the test bumps hold_req, the receiver answers with hold_ack
    rx_style_e rx_style   = RX_RANDOM;
    int        hold_req   = 0;
    int        hold_ack   = 0;
    int        hold_left  = 0;
    logic [15:0] stall_pattern = 16'b1011_0110_1110_0101;

    segment_lcd_frame_serializer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // Segment code of one character; anything not in the table lights nothing
    function automatic logic [7:0] segment_code(input logic [7:0] ch, input bit lower_row);
        logic [7:0] code;
        code = 8'h00;
        for (int i = 0; i < 22; i++) begin
            if (glyph_rom[i][23:16] == ch) begin
                code = lower_row ? glyph_rom[i][7:0] : glyph_rom[i][15:8];
            end
        end
        return code;
    endfunction

    // Work out the words one accepted item shifts out and queue them in order
    function automatic void serialize_item(input lcd_item_t it);
        logic [7:0] seg [8];
        lcd_word_t  w;
        if (it.op == slfs_pkg::OP_COMMAND) begin
            w = '{bits: {CMD_LEAD, it.cmd, 1'b0}, count: BITS_COMMAND, msb_first: 1'b1,
                  last: 1'b1};
            lcd_words_due.push_back(w);
            return;
        end
        // Upper row fills bytes 0..3 left to right, lower row fills 7..4
        for (int p = 0; p < 4; p++) begin
            seg[p]     = segment_code(it.row_one[24 - 8*p +: 8], 1'b0);
            seg[7 - p] = segment_code(it.row_two[24 - 8*p +: 8], 1'b1);
        end
        if (it.dots[0])    seg[2] |= 8'h80;
        if (it.dots[1])    seg[5] |= 8'h08;
        if (it.symbols[0]) seg[1] |= 8'h80;
        if (it.symbols[1]) seg[3] |= 8'h80;
        if (it.symbols[2]) seg[4] |= 8'h08;
        if (it.symbols[3]) seg[6] |= 8'h08;
        if (it.symbols[4]) seg[7] |= 8'h08;
        w = '{bits: WRITE_HEADER, count: BITS_HEADER, msb_first: 1'b1, last: 1'b0};
        lcd_words_due.push_back(w);
        for (int p = 0; p < 8; p++) begin
            w = '{bits: {4'h0, seg[p]}, count: BITS_SEGMENT, msb_first: 1'b0,
                  last: (p == 7)};
            lcd_words_due.push_back(w);
        end
    endfunction

    function automatic lcd_item_t make_frame(input logic [31:0] r1, input logic [31:0] r2,
                                             input logic [1:0] dots, input logic [4:0] syms,
                                             input logic [7:0] cmd);
        return '{op: slfs_pkg::OP_FRAME, row_one: r1, row_two: r2, dots: dots,
                 symbols: syms, cmd: cmd};
    endfunction

    function automatic lcd_item_t make_command(input logic [7:0] cmd, input logic [31:0] junk);
        return '{op: slfs_pkg::OP_COMMAND, row_one: junk, row_two: ~junk, dots: junk[1:0],
                 symbols: junk[6:2], cmd: cmd};
    endfunction

    // Mostly known characters, with unknown codes, zeros and spaces mixed in
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return glyph_rom[$urandom_range(0, 21)][23:16];
        if (roll < 85) return 8'($urandom_range(0, 255));
        if (roll < 93) return 8'h00;
        return 8'h20;
    endfunction

    function automatic lcd_item_t random_item();
        lcd_item_t it;
        it.op      = ($urandom_range(0, 99) < 75) ? slfs_pkg::OP_FRAME : slfs_pkg::OP_COMMAND;
        it.dots    = 2'($urandom_range(0, 3));
        it.symbols = 5'($urandom_range(0, 31));
        it.cmd     = 8'($urandom_range(0, 255));
        for (int b = 0; b < 4; b++) begin
            it.row_one[8*b +: 8] = pick_char();
            it.row_two[8*b +: 8] = pick_char();
        end
        return it;
    endfunction

    // Offer one item and hold it until the block takes it; gaps come between bursts
    task automatic send_item(input lcd_item_t it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 12);
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {1'b0, it.cmd, it.symbols, it.dots, it.row_two, it.row_one};
        do @(posedge aclk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        serialize_item(it);
    endtask

    // Drop valid and wait for every queued word to come back
    task automatic wait_words_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (lcd_words_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [31:0] groups [6];
        groups = '{"0123", "4567", "89CI", "UAHS", "LPEG", "- 0A"};
        gaps_on  = 1'b1;
        rx_style = RX_RANDOM;
        // Every glyph in both rows, each dot and each symbol on its own, then all together
        for (int i = 0; i < 6; i++) begin
            send_item(make_frame(groups[i], groups[(i + 2) % 6], 2'(i % 4),
                                 (i < 5) ? 5'(1 << i) : 5'h1F, 8'(i)));
        end
        send_item(make_frame(32'h0, 32'h0, 2'b00, 5'h00, 8'h00));
        // Codes at and above 0x80 are unknown; command byte is ignored in a frame
        send_item(make_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11, 5'h1F, 8'hFF));
        // Zero bytes decode in place and never shift their neighbours
        send_item(make_frame(32'h3100_2032, 32'h0039_0041, 2'b10, 5'h00, 8'h3C));
        send_item(make_frame("abcz", 32'h7F80_2E2B, 2'b01, 5'h0A, 8'h81));
        // Commands ignore the frame fields
        send_item(make_command(8'h00, 32'hFFFF_FFFF));
        send_item(make_command(8'hFF, 32'h0000_0000));
        send_item(make_command(8'hA5, 32'h1234_5678));
        send_item(make_command(8'h5A, 32'h8765_4321));
        send_item(make_frame("8888", "8888", 2'b11, 5'h1F, 8'h00));
        send_item(make_command(8'h01, 32'hDEAD_BEEF));
        send_item(make_command(8'h80, 32'h0F0F_F0F0));
        wait_words_drained();
    endtask

    task automatic test_random_mix();
        gaps_on = 1'b1;
        for (int n = 0; n < 150; n++) begin
            // Switch the receiver's stall behaviour now and then
            if (n % 40 == 0) rx_style = rx_style_e'($urandom_range(0, 2));
            send_item(random_item());
        end
        wait_words_drained();
    endtask

    task automatic test_backpressure();
        // Hold the receiver off and keep offering frames back to back
        gaps_on  = 1'b0;
        rx_style = RX_RANDOM;
        hold_req++;
        for (int n = 0; n < 30; n++) begin
            send_item(make_frame({pick_char(), pick_char(), pick_char(), pick_char()},
                                 {pick_char(), pick_char(), pick_char(), pick_char()},
                                 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                 8'($urandom_range(0, 255))));
        end
        wait_words_drained();
    endtask

    task automatic test_pause_and_stream();
        // Stream with no idling on either side, pausing once until all words are back
        gaps_on  = 1'b0;
        rx_style = RX_ALWAYS;
        for (int n = 0; n < 10; n++) send_item(random_item());
        wait_words_drained();
        for (int n = 0; n < 10; n++) send_item(random_item());
        wait_words_drained();
    endtask

    // Receiver: long hold-off on request, otherwise the selected stall style
    always @(negedge aclk) begin
        stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 65);
                default:    m_axis_tready <= stall_pattern[15];
            endcase
        end
    end

    // Compare each output transaction with the oldest queued word
    always @(posedge aclk) begin
        lcd_word_t got;
        lcd_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{bits: m_axis_tdata[11:0], count: m_axis_tdata[15:12],
                    msb_first: m_axis_tuser, last: m_axis_tlast};
            if (lcd_words_due.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: bits=%h count=%0d msb_first=%b last=%b",
                             got.bits, got.count, got.msb_first, got.last);
            end else begin
                want = lcd_words_due.pop_front();
                if (got != want) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("word mismatch: bits %h/%h count %0d/%0d msb_first %b/%b %s",
                                 want.bits, got.bits, want.count, got.count,
                                 want.msb_first, got.msb_first,
                                 $sformatf("last %b/%b (expected/actual)", want.last,
                                           got.last));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_mix();
        test_backpressure();
        test_pause_and_stream();
        // Let any stray word surface before the verdict
        rx_style = RX_ALWAYS;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (bad_words == 0 && lcd_words_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/slfs_pkg.sv
src/slfs_lane.sv
src/slfs_merge.sv
src/slfs_serializer.sv
src/segment_lcd_frame_serializer.sv
tb/sv/tb.sv
